>>> hw/rtl/cc20_pkg.sv
package cc20_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned NUM_WORDS     = 16;
   localparam int unsigned POS_W         = 4;
   localparam int unsigned PC_W          = 4;
   localparam int unsigned ROUND_W       = 4;
   localparam int unsigned DOUBLE_ROUNDS = 10;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 64;
   localparam int unsigned COUNT_W       = 3;

   localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(DOUBLE_ROUNDS - 1);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_7   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_8_15  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_16_23 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_24_31 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_0_7 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_8_11 = 3'd5;

   // Program addresses
   localparam logic [PC_W-1:0] STEP_WAIT  = 4'd0;
   localparam logic [PC_W-1:0] STEP_LOAD  = 4'd1;
   localparam logic [PC_W-1:0] STEP_ROUND = 4'd2;
   localparam logic [PC_W-1:0] STEP_LOOP  = 4'd9;
   localparam logic [PC_W-1:0] STEP_FINAL = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT  = 4'd11;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROUND,
      OP_FINAL,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_POS_NZ,
      JMP_ROUND_MORE
   } jump_type;

   typedef struct packed {
      op_type          op;
      logic            take;
      logic            wait_out;
      logic            diag;
      logic [1:0]      phase;
      jump_type        jump;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type cw(op_type op, logic take, logic wait_out, logic diag,
                                        logic [1:0] phase, jump_type jump,
                                        logic [PC_W-1:0] target);
      ctrl_word_type w;
      w.op       = op;
      w.take     = take;
      w.wait_out = wait_out;
      w.diag     = diag;
      w.phase    = phase;
      w.jump     = jump;
      w.target   = target;
      return w;
   endfunction

   // Control store: wait for an item, build, mix and feed forward a block
   // when the position is zero, then emit the result.
   function automatic ctrl_word_type rom_word(logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = cw(OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0, JMP_ALWAYS, STEP_WAIT);
      unique case (pc)
         STEP_WAIT:  w = cw(OP_NONE,  1'b1, 1'b0, 1'b0, 2'd0, JMP_POS_NZ,     STEP_EMIT);
         STEP_LOAD:  w = cw(OP_LOAD,  1'b0, 1'b0, 1'b0, 2'd0, JMP_NEXT,       STEP_WAIT);
         STEP_ROUND: w = cw(OP_ROUND, 1'b0, 1'b0, 1'b0, 2'd0, JMP_NEXT,       STEP_WAIT);
         4'd3:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b0, 2'd1, JMP_NEXT,       STEP_WAIT);
         4'd4:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b0, 2'd2, JMP_NEXT,       STEP_WAIT);
         4'd5:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b0, 2'd3, JMP_NEXT,       STEP_WAIT);
         4'd6:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b1, 2'd0, JMP_NEXT,       STEP_WAIT);
         4'd7:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b1, 2'd1, JMP_NEXT,       STEP_WAIT);
         4'd8:       w = cw(OP_ROUND, 1'b0, 1'b0, 1'b1, 2'd2, JMP_NEXT,       STEP_WAIT);
         STEP_LOOP:  w = cw(OP_ROUND, 1'b0, 1'b0, 1'b1, 2'd3, JMP_ROUND_MORE, STEP_ROUND);
         STEP_FINAL: w = cw(OP_FINAL, 1'b0, 1'b0, 1'b0, 2'd0, JMP_NEXT,       STEP_WAIT);
         STEP_EMIT:  w = cw(OP_EMIT,  1'b0, 1'b1, 1'b0, 2'd0, JMP_ALWAYS,     STEP_WAIT);
         default:    w = cw(OP_NONE,  1'b0, 1'b0, 1'b0, 2'd0, JMP_ALWAYS,     STEP_WAIT);
      endcase
      return w;
   endfunction

   // Rotation amounts of the four quarter-round phases: 16, 12, 8, 7
   function automatic logic [WORD_W-1:0] rot_phase(logic [WORD_W-1:0] v, logic [1:0] phase);
      logic [WORD_W-1:0] r;
      unique case (phase)
         2'd0: r = {v[15:0], v[31:16]};
         2'd1: r = {v[19:0], v[31:20]};
         2'd2: r = {v[23:0], v[31:24]};
         2'd3: r = {v[24:0], v[31:25]};
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] byte_mask(logic [COUNT_W-1:0] cnt);
      logic [WORD_W-1:0] m;
      unique case (cnt)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

>>> hw/rtl/chacha20_stream_cipher_top.sv
// ChaCha20 stream cipher (20 rounds, 32-bit block counter, 96-bit nonce).
//
// Load the key and nonce through the csr_ port while the block is idle;
// register 5 keeps the low 32 bits of its data, indexes 6 and 7 are ignored.
// Message words enter on the req_ channel (req_valid / req_stall), one item
// per word, and leave XORed with keystream on the rsp_ channel. Bytes above
// req_byte_count are returned as zero; the count and end flag pass through.
//
// A small control program steps a datapath of sixteen state words and four
// quarter-round lanes. Each lane does one add, xor and rotate per cycle.
// A word that opens a keystream block (position zero) goes through the
// load, round, feed-forward and emit steps before the next acceptance;
// every other word goes straight to its emit step, where the result is
// loaded into the output register. One item is worked on at a time.
//
// The result sits in an output register: a stalled receiver holds it there,
// and the block still takes the next item, holding in its emit step only if
// the previous result has not left. Synchronous reset clears the key, nonce
// and control state, sets the block counter to 1 and word position to 0.
// An item with end_of_message set returns the counter to 1 and position to 0.
module chacha20_stream_cipher_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cc20_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_data_in,
   input  logic [2:0]                     req_byte_count,
   input  logic                           req_end_of_message,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_data_out,
   output logic [2:0]                     rsp_byte_count_out,
   output logic                           rsp_last_out
);
   import cc20_pkg::*;

   // Configuration
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce0_ff;
   logic [31:0] nonce1_ff;

   // Sequencer
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   ctrl_word_type      ctl;
   logic               hold;

   // Block state
   logic [WORD_W-1:0] counter_ff, counter_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] work_ff [NUM_WORDS];
   logic [WORD_W-1:0] work_in [NUM_WORDS];
   logic [WORD_W-1:0] init_w  [NUM_WORDS];

   // Held item and output register
   logic [WORD_W-1:0]  hold_data_ff;
   logic [COUNT_W-1:0] hold_count_ff;
   logic               hold_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   logic req_accept, out_busy, emit_fire;

   // Lane wiring
   logic [3:0]        x_idx [4];
   logic [3:0]        y_idx [4];
   logic [3:0]        z_idx [4];
   logic [WORD_W-1:0] x_sum [4];
   logic [WORD_W-1:0] z_rot [4];

   assign ctl        = rom_word(pc_ff);
   assign req_stall  = reset | ~ctl.take;
   assign req_accept = req_valid & ~req_stall;
   assign out_busy   = rsp_valid_ff & rsp_stall;
   assign hold       = (ctl.take & ~req_accept) | (ctl.wait_out & out_busy);
   assign emit_fire  = (ctl.op == OP_EMIT) & ~out_busy;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_byte_count_out = rsp_count_ff;
   assign rsp_last_out       = rsp_last_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff   <= '0;
         key1_ff   <= '0;
         key2_ff   <= '0;
         key3_ff   <= '0;
         nonce0_ff <= '0;
         nonce1_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_0_7:    key0_ff   <= csr_wdata;
            CSR_KEY_8_15:   key1_ff   <= csr_wdata;
            CSR_KEY_16_23:  key2_ff   <= csr_wdata;
            CSR_KEY_24_31:  key3_ff   <= csr_wdata;
            CSR_NONCE_0_7:  nonce0_ff <= csr_wdata;
            CSR_NONCE_8_11: nonce1_ff <= csr_wdata[31:0];
            default: ;      // drop writes beyond the register list
         endcase
      end
   end

   // Initial block state, rebuilt from the registers each time it is needed;
   // the counter advances after feed-forward and resets to 1 after a last item.
   always_comb begin
      init_w[0]  = SIGMA_0;
      init_w[1]  = SIGMA_1;
      init_w[2]  = SIGMA_2;
      init_w[3]  = SIGMA_3;
      init_w[4]  = key0_ff[31:0];
      init_w[5]  = key0_ff[63:32];
      init_w[6]  = key1_ff[31:0];
      init_w[7]  = key1_ff[63:32];
      init_w[8]  = key2_ff[31:0];
      init_w[9]  = key2_ff[63:32];
      init_w[10] = key3_ff[31:0];
      init_w[11] = key3_ff[63:32];
      init_w[12] = counter_ff;
      init_w[13] = nonce0_ff[31:0];
      init_w[14] = nonce0_ff[63:32];
      init_w[15] = nonce1_ff;
   end

   // Four quarter-round lanes. Column steps use words (l, 4+l, 8+l, 12+l),
   // diagonal steps shift rows b, c, d by one, two and three places.
   // Even phases: a += b, d = rot(d ^ a). Odd phases: c += d, b = rot(b ^ c).
   always_comb begin
      logic [1:0] lb, lc, ld;
      for (int l = 0; l < 4; l++) begin
         lb = 2'(l) + {1'b0, ctl.diag};
         lc = 2'(l) + {ctl.diag, 1'b0};
         ld = 2'(l) + {ctl.diag, ctl.diag};
         if (ctl.phase[0]) begin
            x_idx[l] = {2'b10, lc};
            y_idx[l] = {2'b11, ld};
            z_idx[l] = {2'b01, lb};
         end else begin
            x_idx[l] = {2'b00, 2'(l)};
            y_idx[l] = {2'b01, lb};
            z_idx[l] = {2'b11, ld};
         end
         x_sum[l] = work_ff[x_idx[l]] + work_ff[y_idx[l]];
         z_rot[l] = rot_phase(work_ff[z_idx[l]] ^ x_sum[l], ctl.phase);
      end
   end

   always_comb begin
      work_in = work_ff;
      unique case (ctl.op)
         OP_LOAD: begin
            work_in = init_w;
         end
         OP_ROUND: begin
            for (int l = 0; l < 4; l++) begin
               work_in[x_idx[l]] = x_sum[l];
               work_in[z_idx[l]] = z_rot[l];
            end
         end
         OP_FINAL: begin
            for (int i = 0; i < NUM_WORDS; i++) begin
               work_in[i] = work_ff[i] + init_w[i];
            end
         end
         OP_NONE, OP_EMIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // Sequencer: hold, branch or advance
   always_comb begin
      pc_in    = pc_ff;
      round_in = round_ff;
      if (!hold) begin
         unique case (ctl.jump)
            JMP_NEXT:   pc_in = pc_ff + 1'b1;
            JMP_ALWAYS: pc_in = ctl.target;
            JMP_POS_NZ: pc_in = (pos_ff != '0) ? ctl.target : pc_ff + 1'b1;
            JMP_ROUND_MORE: begin
               if (round_ff != ROUND_LAST) begin
                  pc_in    = ctl.target;
                  round_in = round_ff + 1'b1;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  round_in = '0;
               end
            end
         endcase
      end
   end

   // Counter and position
   always_comb begin
      counter_in = counter_ff;
      pos_in     = pos_ff;
      if (ctl.op == OP_FINAL) begin
         counter_in = counter_ff + 1'b1;
      end
      if (emit_fire) begin
         pos_in = pos_ff + 1'b1;
         if (hold_last_ff) begin
            counter_in = WORD_W'(1);
            pos_in     = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         round_ff     <= '0;
         counter_ff   <= WORD_W'(1);
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         round_ff     <= round_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the item on acceptance; load the result when it is emitted
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_data_ff  <= req_data_in;
         hold_count_ff <= req_byte_count;
         hold_last_ff  <= req_end_of_message;
      end
      if (emit_fire) begin
         rsp_data_ff  <= (hold_data_ff ^ work_ff[pos_ff]) & byte_mask(hold_count_ff);
         rsp_count_ff <= hold_count_ff;
         rsp_last_ff  <= hold_last_ff;
      end
   end

endmodule

>>> hw/rtl/cc20_checker.sv
module cc20_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_data_out,
   input logic [2:0]  rsp_byte_count_out,
   input logic        rsp_last_out
);

   // A stalled result stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result does not change
   a_rsp_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data_out) && $stable(rsp_byte_count_out)
                                 && $stable(rsp_last_out))
      else $error("result changed while stalled");

   // One item at a time: after an acceptance the input side stalls
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // Bytes beyond the valid count are zero
   a_zero_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_count_out == 3'd0 && rsp_data_out != 32'h0)
                 && !(rsp_byte_count_out == 3'd1 && rsp_data_out[31:8] != 24'h0)
                 && !(rsp_byte_count_out == 3'd2 && rsp_data_out[31:16] != 16'h0)
                 && !(rsp_byte_count_out == 3'd3 && rsp_data_out[31:24] != 8'h0))
      else $error("bytes beyond the valid count are not zero");

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (.*);
